[rtl/core/ffba_pkg.sv]
// ----------------------------------------------------------------------------
// ffba_pkg
// shared types and codes of the first-fit block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT   = 2'd1;
   localparam logic [1:0] STATUS_NOT_LIVE = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_RD,
      ST_A_CHK,
      ST_A_SPLIT,
      ST_A_TAKE,
      ST_F_RD,
      ST_F_CHK,
      ST_F_NRD,
      ST_F_NCHK,
      ST_F_MERGE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] offset;
      logic [16:0] granted_bytes;
      logic [16:0] used_bytes;
      logic [16:0] free_bytes;
      logic [16:0] total_bytes;
   } result_type;

endpackage

`default_nettype wire

[rtl/core/ffba_ram.sv]
// ----------------------------------------------------------------------------
// ffba_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                       clock,
   input  wire                       we,
   input  wire [$clog2(DEPTH)-1:0]   waddr,
   input  wire [WIDTH-1:0]           wdata,
   input  wire [$clog2(DEPTH)-1:0]   raddr,
   output logic [WIDTH-1:0]          rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

[rtl/core/ffba_ctrl.sv]
// ----------------------------------------------------------------------------
// ffba_ctrl
// sequencer and shared add/compare datapath walking the block headers
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ctrl #(
   parameter int POOL_BYTES   = 65536,
   parameter int ALIGN_BYTES  = 8,
   parameter int HEADER_BYTES = 16,
   parameter int MIN_PAYLOAD  = 16
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 cfg_we,
   input  wire [16:0]          cfg_pool_bytes,
   input  wire                 item_valid,
   output logic                item_ready,
   input  wire                 item_kind,
   input  wire [15:0]          item_request_bytes,
   input  wire [15:0]          item_block_offset,
   output logic                res_valid,
   input  wire                 res_take,
   output ffba_pkg::result_type res
);

   import ffba_pkg::*;

   localparam int GRAN  = (ALIGN_BYTES < HEADER_BYTES) ? ALIGN_BYTES : HEADER_BYTES;
   localparam int GSH   = $clog2(GRAN);
   localparam int ALSH  = $clog2(ALIGN_BYTES);
   localparam int DEPTH = POOL_BYTES / GRAN;
   localparam int GW    = $clog2(DEPTH);
   localparam int BW    = $clog2(POOL_BYTES) + 1;
   localparam int XW    = ((BW > 17) ? BW : 17) + 1;
   localparam int RW    = XW + 2;

   localparam logic [XW-1:0] HDR      = XW'(HEADER_BYTES);
   localparam logic [XW-1:0] POOL_MIN = XW'(HEADER_BYTES + MIN_PAYLOAD);
   localparam logic [XW-1:0] POOL_MAX = XW'(POOL_BYTES);
   localparam logic [XW-1:0] ALIGN_M1 = XW'(ALIGN_BYTES - 1);

   state_type         state_ff, state_in;
   logic [XW-1:0]     pool_ff, pool_in;
   logic [XW-1:0]     h_ff, h_in;
   logic [XW-1:0]     need_ff, need_in;
   logic [XW-1:0]     size_ff, size_in;
   logic [XW-1:0]     used_ff, used_in;
   logic [XW-1:0]     free_ff, free_in;
   logic [1:0]        status_ff, status_in;
   logic [15:0]       offset_ff, offset_in;
   logic [XW-1:0]     granted_ff, granted_in;
   logic [GW-1:0]     cnt_ff, cnt_in;

   logic              ram_we;
   logic [GW-1:0]     ram_waddr;
   logic [RW-1:0]     ram_wdata;
   logic [GW-1:0]     ram_raddr;
   logic [RW-1:0]     ram_rdata;

   logic              rd_start;
   logic              rd_free;
   logic [XW-1:0]     rd_size;
   logic [XW-1:0]     cfg_ext;
   logic [XW-1:0]     cfg_sat;
   logic [XW-1:0]     req_need;
   logic [XW-1:0]     boff_ext;
   logic [XW-1:0]     walk_next;
   logic              free_ok;

   assign rd_start = ram_rdata[RW-1];
   assign rd_free  = ram_rdata[RW-2];
   assign rd_size  = ram_rdata[XW-1:0];

   // saturated pool size
   assign cfg_ext = XW'(cfg_pool_bytes);
   always_comb begin
      if (cfg_ext < POOL_MIN) begin
         cfg_sat = POOL_MIN;
      end else if (cfg_ext > POOL_MAX) begin
         cfg_sat = POOL_MAX;
      end else begin
         cfg_sat = cfg_ext;
      end
   end

   assign req_need  = ((XW'(item_request_bytes) + ALIGN_M1) >> ALSH) << ALSH;
   assign boff_ext  = XW'(item_block_offset);
   // one shared adder: next header, split point or neighbor
   assign walk_next = h_ff + HDR + ((state_ff == ST_A_SPLIT) ? need_ff : rd_size);
   assign free_ok   = (boff_ext >= HDR) && ((boff_ext - HDR) < pool_ff)
                      && ((item_block_offset & 16'(GRAN - 1)) == 16'd0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == GW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (item_valid) begin
               if (item_kind == KIND_ALLOC) begin
                  state_in = (item_request_bytes == 16'd0) ? ST_DONE : ST_A_RD;
               end else begin
                  state_in = free_ok ? ST_F_RD : ST_DONE;
               end
            end
         end
         ST_A_RD:    state_in = (h_ff >= pool_ff) ? ST_DONE : ST_A_CHK;
         ST_A_CHK: begin
            if (!rd_start) begin
               state_in = ST_DONE;
            end else if (rd_free && rd_size >= need_ff) begin
               state_in = (rd_size > need_ff + HDR) ? ST_A_SPLIT : ST_A_TAKE;
            end else begin
               state_in = ST_A_RD;
            end
         end
         ST_A_SPLIT: state_in = ST_A_TAKE;
         ST_A_TAKE:  state_in = ST_DONE;
         ST_F_RD:    state_in = ST_F_CHK;
         ST_F_CHK: begin
            if (rd_start && !rd_free && walk_next < pool_ff) begin
               state_in = ST_F_NRD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_F_NRD:   state_in = ST_F_NCHK;
         ST_F_NCHK:  state_in = (rd_start && rd_free) ? ST_F_MERGE : ST_DONE;
         ST_F_MERGE: state_in = ST_DONE;
         ST_DONE:    state_in = res_take ? ST_IDLE : ST_DONE;
         default:    state_in = ST_IDLE;
      endcase
      if (cfg_we) begin
         state_in = ST_CLEAR;
      end
   end

   // datapath and ram control
   always_comb begin
      pool_in    = pool_ff;
      h_in       = h_ff;
      need_in    = need_ff;
      size_in    = size_ff;
      used_in    = used_ff;
      free_in    = free_ff;
      status_in  = status_ff;
      offset_in  = offset_ff;
      granted_in = granted_ff;
      cnt_in     = cnt_ff;
      ram_we     = 1'b0;
      ram_waddr  = h_ff[GSH +: GW];
      ram_wdata  = {1'b1, 1'b1, size_ff};
      ram_raddr  = h_ff[GSH +: GW];
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff;
            ram_wdata = {cnt_ff == '0, cnt_ff == '0, pool_ff - HDR};
            cnt_in    = cnt_ff + GW'(1);
         end
         ST_IDLE: begin
            offset_in  = 16'd0;
            granted_in = '0;
            if (item_kind == KIND_ALLOC) begin
               status_in = STATUS_NO_FIT;
               need_in   = req_need;
               h_in      = '0;
            end else begin
               status_in = STATUS_NOT_LIVE;
               h_in      = boff_ext - HDR;
            end
         end
         ST_A_CHK: begin
            size_in = rd_size;
            if (!(rd_free && rd_size >= need_ff)) begin
               h_in = walk_next;
            end
         end
         ST_A_SPLIT: begin
            ram_we    = 1'b1;
            ram_waddr = walk_next[GSH +: GW];
            ram_wdata = {1'b1, 1'b1, size_ff - need_ff - HDR};
            free_in   = free_ff - HDR;
            size_in   = need_ff;
         end
         ST_A_TAKE: begin
            ram_we     = 1'b1;
            ram_wdata  = {1'b1, 1'b0, size_ff};
            used_in    = used_ff + size_ff;
            free_in    = free_ff - size_ff;
            status_in  = STATUS_OK;
            offset_in  = 16'(h_ff + HDR);
            granted_in = size_ff;
         end
         ST_F_CHK: begin
            if (rd_start && !rd_free) begin
               ram_we    = 1'b1;
               ram_wdata = {1'b1, 1'b1, rd_size};
               size_in   = rd_size;
               need_in   = walk_next;
               used_in   = used_ff - rd_size;
               free_in   = free_ff + rd_size;
               status_in = STATUS_OK;
            end
         end
         ST_F_NRD: begin
            ram_raddr = need_ff[GSH +: GW];
         end
         ST_F_NCHK: begin
            if (rd_start && rd_free) begin
               ram_we    = 1'b1;
               ram_waddr = need_ff[GSH +: GW];
               ram_wdata = {1'b0, 1'b0, rd_size};
               size_in   = size_ff + HDR + rd_size;
               free_in   = free_ff + HDR;
            end
         end
         ST_F_MERGE: begin
            ram_we = 1'b1;
         end
         default: begin
         end
      endcase
      if (cfg_we) begin
         pool_in = cfg_sat;
         used_in = '0;
         free_in = cfg_sat - HDR;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pool_ff  <= POOL_MAX;
         used_ff  <= '0;
         free_ff  <= POOL_MAX - HDR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pool_ff  <= pool_in;
         used_ff  <= used_in;
         free_ff  <= free_in;
         cnt_ff   <= cnt_in;
      end
      h_ff       <= h_in;
      need_ff    <= need_in;
      size_ff    <= size_in;
      status_ff  <= status_in;
      offset_ff  <= offset_in;
      granted_ff <= granted_in;
   end

   ffba_ram #(
      .WIDTH (RW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign item_ready        = (state_ff == ST_IDLE) && !cfg_we;
   assign res_valid         = (state_ff == ST_DONE);
   assign res.status        = status_ff;
   assign res.offset        = offset_ff;
   assign res.granted_bytes = granted_ff[16:0];
   assign res.used_bytes    = used_ff[16:0];
   assign res.free_bytes    = free_ff[16:0];
   assign res.total_bytes   = pool_ff[16:0];

endmodule

`default_nettype wire

[rtl/core/first_fit_block_allocator_top.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// first-fit block allocator with split and forward coalesce over a headered
// pool; one result word per request word
// ----------------------------------------------------------------------------
//  channel  dir  handshake         word
//  req_     in   valid / stall     kind, request_bytes, block_offset
//  rsp_     out  valid / stall     status, offset, granted/used/free/total
//  csr_     in   valid / ready     pool_bytes (always ready)
//
//  allocate: one ram read per block header walked, plus a write of the new
//  header when the block is split; a zero-size request goes straight to its result
//  free: the offset check, then the header read and, for a live block, the
//  neighbor read; a free neighbor is merged into the freed block
//  reset and every pool size write start a clearing pass over all
//  POOL_BYTES / granule ram entries (8192 at defaults) with req_stall high
//  a finished word waits in the output register while the next request is taken
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator_top #(
   parameter int POOL_BYTES   = 65536,
   parameter int ALIGN_BYTES  = 8,
   parameter int HEADER_BYTES = 16,
   parameter int MIN_PAYLOAD  = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire [16:0]  csr_pool_bytes,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire         req_kind,
   input  wire [15:0]  req_request_bytes,
   input  wire [15:0]  req_block_offset,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_offset,
   output logic [16:0] rsp_granted_bytes,
   output logic [16:0] rsp_used_bytes,
   output logic [16:0] rsp_free_bytes,
   output logic [16:0] rsp_total_bytes
);

   import ffba_pkg::*;

   logic       item_ready;
   logic       res_valid;
   logic       res_take;
   result_type res;
   result_type out_ff, out_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // config is always taken; the sequencer restarts its clearing pass
   assign csr_ready = 1'b1;
   assign req_stall = !item_ready;

   ffba_ctrl #(
      .POOL_BYTES   (POOL_BYTES),
      .ALIGN_BYTES  (ALIGN_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .MIN_PAYLOAD  (MIN_PAYLOAD)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .cfg_we             (csr_valid),
      .cfg_pool_bytes     (csr_pool_bytes),
      .item_valid         (req_valid),
      .item_ready         (item_ready),
      .item_kind          (req_kind),
      .item_request_bytes (req_request_bytes),
      .item_block_offset  (req_block_offset),
      .res_valid          (res_valid),
      .res_take           (res_take),
      .res                (res)
   );

   // output register, loads when empty or being drained
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (res_take) begin
         out_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = out_ff.status;
   assign rsp_offset        = out_ff.offset;
   assign rsp_granted_bytes = out_ff.granted_bytes;
   assign rsp_used_bytes    = out_ff.used_bytes;
   assign rsp_free_bytes    = out_ff.free_bytes;
   assign rsp_total_bytes   = out_ff.total_bytes;

endmodule

`default_nettype wire
